// ----- rtl/core/rfd_pkg.sv -----
`default_nettype none
package rfd_pkg;

   // q.30 intermediates held in 64 bits, saturating to +-(2^62 - 1)
   typedef logic signed [63:0] q_type;

   localparam q_type ONE_Q30 = 64'sh0000_0000_4000_0000;
   localparam q_type SAT_Q   = 64'sh3FFF_FFFF_FFFF_FFFF;

   localparam int MUL_LAT  = 4;

   // index ratio divider: 62 quotient bits
   localparam int ED_BITS  = 62;
   localparam int ED_STEPS = 2;
   localparam int ED_ST    = ED_BITS / ED_STEPS;

   // square root: 63 root bits
   localparam int SQ_BITS  = 63;
   localparam int SQ_STEPS = 3;
   localparam int SQ_ST    = SQ_BITS / SQ_STEPS;

   // normalizing divider: 33 quotient bits
   localparam int UD_BITS  = 33;
   localparam int UD_STEPS = 3;
   localparam int UD_ST    = UD_BITS / UD_STEPS;

   // pipeline timing, cycles after the input register
   localparam int T_C    = 3;
   localparam int T_OMC  = T_C + MUL_LAT + 1;
   localparam int T_ETA  = ED_ST;
   localparam int T_E2   = T_ETA + MUL_LAT;
   localparam int T_S2   = T_E2 + MUL_LAT;
   localparam int T_T    = T_S2 + 1;
   localparam int T_K    = T_T + SQ_ST;
   localparam int T_COEF = T_K + 1;
   localparam int T_CN   = T_COEF + MUL_LAT;
   localparam int T_V    = T_CN + 1;
   localparam int T_ACC  = T_V + 4;
   localparam int T_LEN  = T_ACC + SQ_ST;
   localparam int T_PRE  = T_LEN + 1;
   localparam int T_UD   = T_PRE + UD_ST;
   localparam int T_OUT  = T_UD + 1;

   function automatic q_type addq(q_type a, q_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(SAT_Q)) begin
         return SAT_Q;
      end
      if (s < -65'(SAT_Q)) begin
         return -SAT_Q;
      end
      return s[63:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rfd_mulq.sv -----
`default_nettype none
module rfd_mulq (
   input  logic          clock,
   input  rfd_pkg::q_type a,
   input  rfd_pkg::q_type b,
   output rfd_pkg::q_type y
);
   import rfd_pkg::*;

   logic [63:0]  ma_ff, mb_ff;
   logic         neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]  pll_ff, plh_ff, phl_ff, phh_ff;
   logic [127:0] p_ff;
   logic [97:0]  q_rnd;
   logic [62:0]  u;
   q_type        y_pos, y_in, y_ff;

   // magnitudes, 32x32 partials, sum, floor and saturate
   always_ff @(posedge clock) begin
      ma_ff   <= a[63] ? 64'(-a) : 64'(a);
      mb_ff   <= b[63] ? 64'(-b) : 64'(b);
      neg1_ff <= a[63] ^ b[63];
      pll_ff  <= ma_ff[31:0] * mb_ff[31:0];
      plh_ff  <= ma_ff[31:0] * mb_ff[63:32];
      phl_ff  <= ma_ff[63:32] * mb_ff[31:0];
      phh_ff  <= ma_ff[63:32] * mb_ff[63:32];
      neg2_ff <= neg1_ff;
      p_ff    <= {64'b0, pll_ff} + {32'b0, plh_ff, 32'b0} + {32'b0, phl_ff, 32'b0}
                 + {phh_ff, 64'b0};
      neg3_ff <= neg2_ff;
      y_ff    <= y_in;
   end

   // negative products round toward minus infinity
   always_comb begin
      q_rnd = p_ff[127:30] + 98'(neg3_ff && (p_ff[29:0] != 30'b0));
      u     = (q_rnd > 98'(SAT_Q)) ? SAT_Q[62:0] : q_rnd[62:0];
      y_pos = {1'b0, u};
      y_in  = neg3_ff ? -y_pos : y_pos;
   end

   assign y = y_ff;

endmodule
`default_nettype wire

// ----- rtl/core/rfd_sqrt.sv -----
`default_nettype none
module rfd_sqrt (
   input  logic         clock,
   input  logic [125:0] radicand,
   output logic [62:0]  root
);
   import rfd_pkg::*;

   logic [125:0] x_ff    [SQ_ST];
   logic [64:0]  rem_ff  [SQ_ST];
   logic [62:0]  root_ff [SQ_ST];

   for (genvar s = 0; s < SQ_ST; s++) begin : g_stage
      logic [125:0] x_src;
      logic [64:0]  rem_src, rem_in;
      logic [62:0]  root_src, root_in;

      if (s == 0) begin : g_first
         assign x_src    = radicand;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign x_src    = x_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      // one root bit per step, two radicand bits brought down
      always_comb begin
         logic [65:0] rw;
         logic [65:0] trial;
         logic [64:0] r;
         logic [62:0] q;
         r = rem_src;
         q = root_src;
         for (int i = 0; i < SQ_STEPS; i++) begin
            rw    = {r[63:0], x_src[2*(SQ_BITS-1-(s*SQ_STEPS+i)) +: 2]};
            trial = {1'b0, q, 2'b01};
            if (rw >= trial) begin
               r = 65'(rw - trial);
               q = {q[61:0], 1'b1};
            end else begin
               r = rw[64:0];
               q = {q[61:0], 1'b0};
            end
         end
         rem_in  = r;
         root_in = q;
      end

      always_ff @(posedge clock) begin
         x_ff[s]    <= x_src;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
      end
   end

   assign root = root_ff[SQ_ST-1];

endmodule
`default_nettype wire

// ----- rtl/core/refraction_direction.sv -----
// snell refraction: one item accepted per clock, busy stays low
// result path: the index divider, two square roots and the normalizing divider lie
//    between the accepting edge and the result strobe
// throughput: one item per cycle, the receiver cannot stall the pipeline
// reset: synchronous, clears all valid bits, items in flight are dropped
`default_nettype none
module refraction_direction (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   input  logic signed [31:0] req_nrm_x,
   input  logic signed [31:0] req_nrm_y,
   input  logic signed [31:0] req_nrm_z,
   input  logic [31:0]        req_old_index,
   input  logic [31:0]        req_new_index,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic signed [31:0] rsp_dir_z,
   output logic               rsp_total_reflection
);
   import rfd_pkg::*;

   // shift line lengths that line up the branches
   localparam int L_C   = T_ETA - T_C;
   localparam int L_OMC = T_E2 - T_OMC;
   localparam int L_IV  = T_ETA;
   localparam int L_EC  = T_K - T_E2;
   localparam int L_NF  = T_COEF - T_C;
   localparam int L_EIV = T_CN - T_E2;
   localparam int L_V   = T_LEN - T_V;
   localparam int L_TR  = T_UD - T_T;

   typedef struct packed {
      logic [62:0] rem;
      logic [32:0] quo;
      logic [2:0]  mlo;
      logic        neg;
      logic        ovf;
   } ud_type;

   // valid bit per pipeline position
   logic [T_OUT:0] vld_ff;

   // input register
   logic signed [31:0] iv_ff [3];
   logic signed [31:0] nv_ff [3];
   logic [31:0]        old_ff, new_ff;

   // dot product and side test
   logic signed [63:0] prod_ff [3];
   logic signed [31:0] nv1_ff [3];
   logic signed [31:0] nv2_ff [3];
   logic signed [65:0] dot_ff;
   logic signed [65:0] cm;
   logic               flip;
   q_type              c_ff;
   logic signed [32:0] nf_ff [3];

   // index ratio divider
   logic [31:0] er_ff [ED_ST];
   logic [31:0] eo_ff [ED_ST];
   logic [31:0] ed_ff [ED_ST];
   logic [61:0] eq_ff [ED_ST];
   q_type       eta;

   // snell terms
   q_type              cc, omc_ff, e2, sin2, ec, coef_ff;
   q_type              ccn;
   logic               tr_ff;
   q_type              t_ff;
   logic [62:0]        k;
   q_type              cd_ff  [L_C];
   q_type              od_ff  [L_OMC];
   logic signed [31:0] ivd_ff [3][L_IV];
   q_type              ecd_ff [L_EC];
   logic signed [32:0] nfd_ff [3][L_NF];
   q_type              eiv    [3];
   q_type              eivd_ff [3][L_EIV];
   q_type              cn     [3];
   q_type              eiv_a  [3];
   q_type              cn_b   [3];

   // refracted vector and its length
   q_type        v_ff   [3];
   q_type        vd_ff  [3][L_V];
   logic [61:0]  mv_ff  [3];
   logic [59:0]  hh_ff  [3];
   logic [61:0]  hl_ff  [3];
   logic [63:0]  ll_ff  [3];
   logic [123:0] sq_ff  [3];
   logic [125:0] acc_ff;
   logic [62:0]  len;
   logic [L_TR-1:0] trd_ff;

   // normalizing divider, one lane per component
   logic [61:0]  pm_ff [3];
   logic         pn_ff [3];
   logic         po_ff [3];
   logic [62:0]  plen_ff;
   ud_type       ud_ff [3][UD_ST];
   logic [62:0]  ul_ff [UD_ST];

   // output register
   logic signed [31:0] dir_in [3];
   logic signed [31:0] dir_ff [3];
   logic               trout_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[T_OUT-1:0], start};
      end
   end

   // capture every cycle, the valid line tells which items are real
   always_ff @(posedge clock) begin
      iv_ff[0] <= req_in_x;
      iv_ff[1] <= req_in_y;
      iv_ff[2] <= req_in_z;
      nv_ff[0] <= req_nrm_x;
      nv_ff[1] <= req_nrm_y;
      nv_ff[2] <= req_nrm_z;
      old_ff   <= req_old_index;
      new_ff   <= req_new_index;
   end

   // exact dot product, normal turned against the ray, cos floored to q.30
   always_comb begin
      flip = dot_ff > 66'sd0;
      cm   = flip ? -dot_ff : dot_ff;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         prod_ff[j] <= iv_ff[j] * nv_ff[j];
         nv1_ff[j]  <= nv_ff[j];
         nv2_ff[j]  <= nv1_ff[j];
         nf_ff[j]   <= flip ? -33'(nv2_ff[j]) : 33'(nv2_ff[j]);
      end
      dot_ff <= 66'(prod_ff[0]) + 66'(prod_ff[1]) + 66'(prod_ff[2]);
      c_ff   <= 64'(cm >>> 30);
   end

   // eta = old_index * 2^30 / new_index, zero divisor taken as one lsb
   for (genvar s = 0; s < ED_ST; s++) begin : g_eta
      logic [31:0] r_src, o_src, d_src, r_nx, o_nx;
      logic [61:0] q_src, q_nx;

      if (s == 0) begin : g_first
         assign r_src = '0;
         assign q_src = '0;
         assign o_src = old_ff;
         assign d_src = (new_ff == 32'd0) ? 32'd1 : new_ff;
      end else begin : g_next
         assign r_src = er_ff[s-1];
         assign q_src = eq_ff[s-1];
         assign o_src = eo_ff[s-1];
         assign d_src = ed_ff[s-1];
      end

      always_comb begin
         logic [32:0] rw;
         logic [31:0] r;
         logic [31:0] o;
         logic [61:0] q;
         r = r_src;
         o = o_src;
         q = q_src;
         for (int i = 0; i < ED_STEPS; i++) begin
            rw = {r, o[31]};
            o  = {o[30:0], 1'b0};
            if (rw >= {1'b0, d_src}) begin
               r = 32'(rw - {1'b0, d_src});
               q = {q[60:0], 1'b1};
            end else begin
               r = rw[31:0];
               q = {q[60:0], 1'b0};
            end
         end
         r_nx = r;
         o_nx = o;
         q_nx = q;
      end

      always_ff @(posedge clock) begin
         er_ff[s] <= r_nx;
         eo_ff[s] <= o_nx;
         ed_ff[s] <= d_src;
         eq_ff[s] <= q_nx;
      end
   end

   assign eta = {2'b0, eq_ff[ED_ST-1]};

   // cos^2, then 1 - cos^2
   rfd_mulq u_mul_cc (.clock(clock), .a(c_ff), .b(c_ff), .y(cc));
   assign ccn = -cc;

   always_ff @(posedge clock) begin
      omc_ff <= addq(ONE_Q30, ccn);
   end

   // shift lines that hold each term until the value it is combined with arrives
   always_ff @(posedge clock) begin
      cd_ff[0] <= c_ff;
      for (int i = 1; i < L_C; i++) cd_ff[i] <= cd_ff[i-1];
      od_ff[0] <= omc_ff;
      for (int i = 1; i < L_OMC; i++) od_ff[i] <= od_ff[i-1];
      ecd_ff[0] <= ec;
      for (int i = 1; i < L_EC; i++) ecd_ff[i] <= ecd_ff[i-1];
      for (int j = 0; j < 3; j++) begin
         ivd_ff[j][0] <= iv_ff[j];
         for (int i = 1; i < L_IV; i++) ivd_ff[j][i] <= ivd_ff[j][i-1];
         nfd_ff[j][0] <= nf_ff[j];
         for (int i = 1; i < L_NF; i++) nfd_ff[j][i] <= nfd_ff[j][i-1];
         eivd_ff[j][0] <= eiv[j];
         for (int i = 1; i < L_EIV; i++) eivd_ff[j][i] <= eivd_ff[j][i-1];
         vd_ff[j][0] <= v_ff[j];
         for (int i = 1; i < L_V; i++) vd_ff[j][i] <= vd_ff[j][i-1];
      end
      trd_ff <= {trd_ff[L_TR-2:0], tr_ff};
   end

   // sin^2 = eta^2 * (1 - cos^2), and eta * cos for the normal coefficient
   rfd_mulq u_mul_e2 (.clock(clock), .a(eta), .b(eta), .y(e2));
   rfd_mulq u_mul_s2 (.clock(clock), .a(e2), .b(od_ff[L_OMC-1]), .y(sin2));
   rfd_mulq u_mul_ec (.clock(clock), .a(eta), .b(cd_ff[L_C-1]), .y(ec));

   // total reflection test and 1 - sin^2
   always_ff @(posedge clock) begin
      tr_ff <= sin2 > ONE_Q30;
      t_ff  <= addq(ONE_Q30, -sin2);
   end

   // sqrt(1 - sin^2) in q.30
   rfd_sqrt u_sqrt_k (
      .clock    (clock),
      .radicand ({33'b0, t_ff[62:0], 30'b0}),
      .root     (k)
   );

   always_ff @(posedge clock) begin
      coef_ff <= addq(ecd_ff[L_EC-1], {1'b0, k});
   end

   // v = eta * in - coef * normal, per component
   for (genvar j = 0; j < 3; j++) begin : g_lane
      assign eiv_a[j] = 64'(ivd_ff[j][L_IV-1]);
      assign cn_b[j]  = 64'(nfd_ff[j][L_NF-1]);
      rfd_mulq u_mul_eiv (.clock(clock), .a(eta), .b(eiv_a[j]), .y(eiv[j]));
      rfd_mulq u_mul_cn (.clock(clock), .a(coef_ff), .b(cn_b[j]), .y(cn[j]));
   end

   // exact squared length: magnitude, partials, per-lane sum, total
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         v_ff[j]  <= addq(eivd_ff[j][L_EIV-1], -cn[j]);
         mv_ff[j] <= v_ff[j][63] ? 62'(-v_ff[j]) : v_ff[j][61:0];
         hh_ff[j] <= mv_ff[j][61:32] * mv_ff[j][61:32];
         hl_ff[j] <= mv_ff[j][61:32] * mv_ff[j][31:0];
         ll_ff[j] <= mv_ff[j][31:0] * mv_ff[j][31:0];
         sq_ff[j] <= {hh_ff[j], 64'b0} + {29'b0, hl_ff[j], 33'b0} + {60'b0, ll_ff[j]};
      end
      acc_ff <= 126'(sq_ff[0]) + 126'(sq_ff[1]) + 126'(sq_ff[2]);
   end

   rfd_sqrt u_sqrt_len (.clock(clock), .radicand(acc_ff), .root(len));

   // divider setup: magnitude, sign, and overflow when |v| >= 8 * len
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         pm_ff[j] <= vd_ff[j][L_V-1][63] ? 62'(-vd_ff[j][L_V-1]) : vd_ff[j][L_V-1][61:0];
         pn_ff[j] <= vd_ff[j][L_V-1][63];
         po_ff[j] <= {4'b0, (vd_ff[j][L_V-1][63] ? 62'(-vd_ff[j][L_V-1])
                                                  : vd_ff[j][L_V-1][61:0])} >= {len, 3'b0};
      end
      plen_ff <= len;
   end

   // v * 2^30 / len, low 33 quotient bits, remainder starts at |v| >> 3
   for (genvar s = 0; s < UD_ST; s++) begin : g_ud
      logic [62:0] l_src;

      if (s == 0) begin : g_first
         assign l_src = plen_ff;
      end else begin : g_next
         assign l_src = ul_ff[s-1];
      end

      always_ff @(posedge clock) begin
         ul_ff[s] <= l_src;
      end

      for (genvar j = 0; j < 3; j++) begin : g_lane
         ud_type d_src, d_nx;

         if (s == 0) begin : g_first
            assign d_src = '{rem: {4'b0, pm_ff[j][61:3]}, quo: '0, mlo: pm_ff[j][2:0],
                             neg: pn_ff[j], ovf: po_ff[j]};
         end else begin : g_next
            assign d_src = ud_ff[j][s-1];
         end

         always_comb begin
            logic [63:0] rw;
            d_nx = d_src;
            for (int i = 0; i < UD_STEPS; i++) begin
               rw       = {d_nx.rem, d_nx.mlo[2]};
               d_nx.mlo = {d_nx.mlo[1:0], 1'b0};
               if (rw >= {1'b0, l_src}) begin
                  d_nx.rem = 63'(rw - {1'b0, l_src});
                  d_nx.quo = {d_nx.quo[31:0], 1'b1};
               end else begin
                  d_nx.rem = rw[62:0];
                  d_nx.quo = {d_nx.quo[31:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            ud_ff[j][s] <= d_nx;
         end
      end
   end

   // saturate to the signed 32-bit range, zero on total reflection or zero length
   always_comb begin
      logic [32:0] lim;
      logic [32:0] qs;
      logic [31:0] mg;
      for (int j = 0; j < 3; j++) begin
         lim = ud_ff[j][UD_ST-1].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
         qs  = (ud_ff[j][UD_ST-1].ovf || ud_ff[j][UD_ST-1].quo > lim) ? lim
                                                                     : ud_ff[j][UD_ST-1].quo;
         mg  = ud_ff[j][UD_ST-1].neg ? -qs[31:0] : qs[31:0];
         dir_in[j] = (trd_ff[L_TR-1] || ul_ff[UD_ST-1] == 63'd0) ? 32'sd0 : mg;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) dir_ff[j] <= dir_in[j];
      trout_ff <= trd_ff[L_TR-1];
   end

   assign rsp_strobe           = vld_ff[T_OUT];
   assign rsp_dir_x            = dir_ff[0];
   assign rsp_dir_y            = dir_ff[1];
   assign rsp_dir_z            = dir_ff[2];
   assign rsp_total_reflection = trout_ff;

   // every accepted item comes out after the fixed pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(T_OUT+1) rsp_strobe)
      else $error("result strobe missing after accepted item");

   // a reflected ray gives the zero vector
   a_tr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_total_reflection |->
         rsp_dir_x == 32'sd0 && rsp_dir_y == 32'sd0 && rsp_dir_z == 32'sd0)
      else $error("nonzero direction on total reflection");

   // index divider leaves a remainder below the divisor
   a_eta_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T_ETA] |-> er_ff[ED_ST-1] < ed_ff[ED_ST-1])
      else $error("index divider remainder out of range");

   // square root operand is never negative for a refracted ray
   a_t_sign: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T_T] && !tr_ff |-> !t_ff[63])
      else $error("negative cosine term without total reflection");

endmodule
`default_nettype wire
